>>> rtl/core/toon_shade_pixel_defines.svh
// ----------------------------------------------------------------------------
// Toon shade pixel assertion macros
// Shared concurrent assertion helpers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TOON_SHADE_PIXEL_DEFINES_SVH
`define TOON_SHADE_PIXEL_DEFINES_SVH

// same-cycle implication
`define TSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Toon shade pixel package
// Shared types and fixed constants of the cel shading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tsp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int KIND_W      = 2;
  localparam int Q_W         = 16;     // Q1.15 weight width
  localparam int Q_FRAC      = 15;
  localparam int ONE_Q15     = 32768;
  localparam int HALF_Q15    = 16384;
  localparam int OUTLINE_Q15 = 3277;   // 0.1 in Q1.15
  localparam int BLEND_SHIFT = 30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BAND_COUNT = 3'd0,
    CFG_BAND_THR   = 3'd1,
    CFG_BAND_LOW   = 3'd2,
    CFG_BAND_HIGH  = 3'd3,
    CFG_OUTLINE    = 3'd4,
    CFG_BG_LEFT    = 3'd5,
    CFG_BG_RIGHT   = 3'd6
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BG      = 2'd0,
    KIND_OUTLINE = 2'd1,
    KIND_BAND    = 2'd2
  } pixel_kind_t;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iter_ctl_t;

  typedef struct packed {
    logic done;
  } iter_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/tsp_mac.sv
// ----------------------------------------------------------------------------
// Toon shade pixel multiply-accumulate
// One signed multiplier feeding a registered accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tsp_mac #(
  parameter int MW = 24,
  parameter int AW = 50
) (
  input  logic                 clk,
  input  tsp_pkg::mac_ctl_t    ctl,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [AW-1:0] acc
);
  import tsp_pkg::*;

  logic signed [2*MW-1:0] prod;
  logic signed [AW-1:0]   acc_r;
  logic signed [AW-1:0]   acc_nxt;

  assign prod    = a * b;
  assign acc_nxt = (ctl.clr ? AW'(0) : acc_r) + AW'(prod);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

>>> rtl/core/tsp_iter.sv
// ----------------------------------------------------------------------------
// Toon shade pixel shift-subtract unit
// Restoring square root (two bits a step) or division (one bit a step).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tsp_iter #(
  parameter int DW       = 47,
  parameter int RW       = 31,
  parameter int SQ_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tsp_pkg::iter_ctl_t ctl,
  input  logic [DW-1:0]      src,
  input  logic [RW-1:0]      den,
  output tsp_pkg::iter_sts_t sts,
  output logic [DW-1:0]      q
);
  import tsp_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          run_r, done_r, sqrt_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] src_r, q_r;
  logic [RW-1:0] rem_r, den_r;
  logic [RW+1:0] rem_sh, trial, diff;
  logic          ge;

  always_comb begin
    if (sqrt_r) begin
      rem_sh = {rem_r, src_r[DW-1 -: 2]};
      trial  = {q_r[RW-1:0], 2'b01};
    end else begin
      rem_sh = {1'b0, rem_r, src_r[DW-1]};
      trial  = {2'b00, den_r};
    end
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        run_r <= 1'b1;
        cnt_r <= ctl.sqrt_mode ? CW'(SQ_STEPS) : CW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      src_r  <= src;
      den_r  <= den;
      sqrt_r <= ctl.sqrt_mode;
      q_r    <= '0;
      rem_r  <= '0;
    end else if (run_r) begin
      src_r <= sqrt_r ? (src_r << 2) : (src_r << 1);
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
    end
  end

  assign sts.done = done_r;
  assign q        = q_r;

endmodule
`default_nettype wire

>>> rtl/core/toon_shade_pixel.sv
// ----------------------------------------------------------------------------
// Toon shade pixel
// Cel shading of one pixel from a stream of per-light words.
// ----------------------------------------------------------------------------
// Sequencing: a shaded light word runs one sqrt and one divide on the shared
//   shift-subtract unit: VECTOR_BITS sqrt steps and 2*VECTOR_BITS+15 divide
//   steps. The first word of a miss runs one sqrt, two divides (none for a
//   zero-length ray) and a blend of the three channels.
// Throughput: one word at a time; in_ready is low while a word is worked on.
// Reset: synchronous active-low; only config and sequencer registers reset.
`timescale 1ns / 1ps
`default_nettype none
`include "toon_shade_pixel_defines.svh"
module toon_shade_pixel #(
  parameter int MAX_BANDS    = 4,
  parameter int VECTOR_BITS  = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_hit,
  input  logic signed [VECTOR_BITS-1:0]   in_normal_x,
  input  logic signed [VECTOR_BITS-1:0]   in_normal_y,
  input  logic signed [VECTOR_BITS-1:0]   in_normal_z,
  input  logic signed [VECTOR_BITS-1:0]   in_ray_x,
  input  logic signed [VECTOR_BITS-1:0]   in_ray_y,
  input  logic signed [VECTOR_BITS-1:0]   in_ray_z,
  input  logic signed [VECTOR_BITS-1:0]   in_light_x,
  input  logic signed [VECTOR_BITS-1:0]   in_light_y,
  input  logic signed [VECTOR_BITS-1:0]   in_light_z,
  input  logic                            in_has_light,
  input  logic                            in_last_light,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [CHANNEL_BITS-1:0]         out_red,
  output logic [CHANNEL_BITS-1:0]         out_green,
  output logic [CHANNEL_BITS-1:0]         out_blue,
  output logic [tsp_pkg::KIND_W-1:0]      out_pixel_kind,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tsp_pkg::*;

  localparam int V    = VECTOR_BITS;
  localparam int FRAC = V - 2;               // Q1.14 at 16 bits
  localparam int SQW  = 2 * V;               // sum of squares / |dot|
  localparam int DW   = SQW + Q_FRAC;        // dividend, scaled by 2^15
  localparam int RW   = 2 * V - 1;           // remainder / divisor
  localparam int MW   = (V > 24) ? V : 24;   // multiplier operand
  localparam int AW   = 2 * MW + 2;

  // sequencer, one-hot
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQ    = 10'b0000000010,
    S_KSQRT = 10'b0000000100,
    S_WSQRT = 10'b0000001000,
    S_DOT   = 10'b0000010000,
    S_KDIV  = 10'b0000100000,
    S_WDIV  = 10'b0001000000,
    S_BAND  = 10'b0010000000,
    S_BLEND = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  // what the running divide is for
  typedef enum logic [1:0] {
    TAG_X, TAG_Y, TAG_OUTL, TAG_LIGHT
  } div_tag_t;

  // ---- configuration ----
  logic [2:0]  band_count_r;
  logic [63:0] thr_r;
  logic [47:0] bcl_r, bch_r, bgl_r, bgr_r;
  logic [23:0] outl_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r <= 3'd4;
      thr_r        <= '0;
      bcl_r        <= '0;
      bch_r        <= '0;
      outl_r       <= '0;
      bgl_r        <= '0;
      bgr_r        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BAND_COUNT: band_count_r <= cfg_data[2:0];
        CFG_BAND_THR:   thr_r        <= cfg_data;
        CFG_BAND_LOW:   bcl_r        <= cfg_data[47:0];
        CFG_BAND_HIGH:  bch_r        <= cfg_data[47:0];
        CFG_OUTLINE:    outl_r       <= cfg_data[23:0];
        CFG_BG_LEFT:    bgl_r        <= cfg_data[47:0];
        CFG_BG_RIGHT:   bgr_r        <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // ---- state ----
  state_t      state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        vsel_r, vsel_nxt;       // 0 ray, 1 light
  div_tag_t    tag_r, tag_nxt;
  logic [1:0]  ch_r, ch_nxt;           // 0 blue, 1 green, 2 red
  logic [2:0]  sub_r, sub_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        mid_r, mid_nxt;
  logic [7:0]  max_r [3];
  logic [7:0]  max_nxt [3];
  logic        out_valid_r, out_valid_nxt;

  // word latches and datapath payload
  logic                hit_r, hit_nxt, has_light_r, has_light_nxt, last_r, last_nxt;
  logic signed [V-1:0] n_r [3];
  logic signed [V-1:0] n_nxt [3];
  logic signed [V-1:0] ray_r [3];
  logic signed [V-1:0] ray_nxt [3];
  logic signed [V-1:0] light_r [3];
  logic signed [V-1:0] light_nxt [3];
  logic [V-1:0]        len_r, len_nxt;
  logic                neg_r, neg_nxt;
  logic signed [DW:0]  c_r, c_nxt;
  logic [Q_W-1:0]      tx_r, tx_nxt, ty_r, ty_nxt;
  logic [MW-1:0]       left_r, left_nxt;
  logic [CHANNEL_BITS-1:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;

  // ---- shared units ----
  mac_ctl_t             mac_ctl;
  logic signed [MW-1:0] mac_a, mac_b;
  logic signed [AW-1:0] acc;
  iter_ctl_t            iter_ctl;
  iter_sts_t            iter_sts;
  logic [DW-1:0]        iter_src, iter_q;
  logic [RW-1:0]        iter_den;

  tsp_mac #(.MW(MW), .AW(AW)) u_mac (
    .clk(clk), .ctl(mac_ctl), .a(mac_a), .b(mac_b), .acc(acc)
  );

  tsp_iter #(.DW(DW), .RW(RW), .SQ_STEPS(V)) u_iter (
    .clk(clk), .rst_n(rst_n), .ctl(iter_ctl), .src(iter_src), .den(iter_den),
    .sts(iter_sts), .q(iter_q)
  );

  // ---- helpers ----
  logic signed [V-1:0]   vec_c, comp_c;
  logic signed [V:0]     comp_ext, comp_abs;
  logic signed [AW:0]    nd, nd_abs;
  logic signed [DW:0]    c_div;
  logic signed [DW+1:0]  c_off, w_c;
  logic [Q_W-1:0]        half_c;
  logic [2:0]            bands_c;
  logic                  band_hit;
  logic [1:0]            band_sel;
  logic [23:0]           band_rgb;
  logic [16:0]           wy0, wx0;
  logic [AW-1:0]         rnd_c;

  assign vec_c    = vsel_r ? light_r[cnt_r] : ray_r[cnt_r];
  assign comp_c   = (tag_r == TAG_X) ? ray_r[0] : ray_r[1];
  assign comp_ext = {comp_c[V-1], comp_c};
  assign comp_abs = comp_ext[V] ? -comp_ext : comp_ext;
  assign nd       = -{acc[AW-1], acc};
  assign nd_abs   = nd[AW] ? -nd : nd;

  // signed quotient and its blend weight (c+1)/2
  assign c_div  = neg_r ? -$signed({1'b0, iter_q}) : $signed({1'b0, iter_q});
  assign c_off  = {c_div[DW], c_div} + $signed((DW+2)'(ONE_Q15));
  assign half_c = c_off[Q_W:1];

  assign wy0   = 17'(ONE_Q15) - {1'b0, ty_r};
  assign wx0   = 17'(ONE_Q15) - {1'b0, tx_r};
  assign rnd_c = acc + (AW'(1) << (BLEND_SHIFT - 1));

  // band pick: highest band whose threshold 1-cos reaches; a negative cos takes the last band
  always_comb begin
    if (band_count_r == 3'd0) begin
      bands_c = 3'd1;
    end else if (band_count_r > 3'(MAX_BANDS)) begin
      bands_c = 3'(MAX_BANDS);
    end else begin
      bands_c = band_count_r;
    end
    w_c      = $signed((DW+2)'(ONE_Q15)) - {c_r[DW], c_r};
    band_hit = 1'b0;
    band_sel = '0;
    for (int j = 0; j < MAX_BANDS; j++) begin
      if (3'(j) < bands_c &&
          w_c >= $signed({{(DW+2-Q_W){1'b0}}, thr_r[Q_W*j +: Q_W]})) begin
        band_hit = 1'b1;
        band_sel = 2'(j);
      end
    end
    if (c_r[DW]) begin
      band_hit = 1'b1;
      band_sel = 2'(bands_c - 3'd1);
    end
    if (band_sel[1]) begin
      band_rgb = band_sel[0] ? bch_r[47:24] : bch_r[23:0];
    end else begin
      band_rgb = band_sel[0] ? bcl_r[47:24] : bcl_r[23:0];
    end
  end

  function automatic logic [CHANNEL_BITS-1:0] widen(input logic [7:0] v);
    logic [15:0] d;
    d = {v, v};
    return d[15 -: CHANNEL_BITS];
  endfunction

  // ---- sequencer ----
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    vsel_nxt      = vsel_r;
    tag_nxt       = tag_r;
    ch_nxt        = ch_r;
    sub_nxt       = sub_r;
    mode_nxt      = mode_r;
    mid_nxt       = mid_r;
    max_nxt       = max_r;
    out_valid_nxt = out_valid_r;
    hit_nxt       = hit_r;
    has_light_nxt = has_light_r;
    last_nxt      = last_r;
    n_nxt         = n_r;
    ray_nxt       = ray_r;
    light_nxt     = light_r;
    len_nxt       = len_r;
    neg_nxt       = neg_r;
    c_nxt         = c_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    left_nxt      = left_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    kind_nxt      = kind_r;
    mac_ctl       = '0;
    mac_a         = '0;
    mac_b         = '0;
    iter_ctl      = '0;
    iter_src      = '0;
    iter_den      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          hit_nxt       = in_hit;
          has_light_nxt = in_has_light;
          last_nxt      = in_last_light;
          n_nxt[0]      = in_normal_x;
          n_nxt[1]      = in_normal_y;
          n_nxt[2]      = in_normal_z;
          ray_nxt[0]    = in_ray_x;
          ray_nxt[1]    = in_ray_y;
          ray_nxt[2]    = in_ray_z;
          light_nxt[0]  = in_light_x;
          light_nxt[1]  = in_light_y;
          light_nxt[2]  = in_light_z;
          cnt_nxt       = '0;
          if (!mid_r) begin
            // first word of the pixel decides its kind
            mid_nxt    = 1'b1;
            max_nxt[0] = '0;
            max_nxt[1] = '0;
            max_nxt[2] = '0;
            mode_nxt   = in_hit ? KIND_BAND : KIND_BG;
            vsel_nxt   = 1'b0;
            state_nxt  = S_SQ;
          end else if (mode_r == KIND_BAND && in_has_light) begin
            vsel_nxt  = 1'b1;
            state_nxt = S_SQ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SQ: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (cnt_r == 2'd0);
        mac_a       = MW'(vec_c);
        mac_b       = MW'(vec_c);
        if (cnt_r == 2'd2) begin
          state_nxt = S_KSQRT;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end

      S_KSQRT: begin
        iter_ctl.start     = 1'b1;
        iter_ctl.sqrt_mode = 1'b1;
        iter_src           = {acc[SQW-1:0], {Q_FRAC{1'b0}}};
        state_nxt          = S_WSQRT;
      end

      S_WSQRT: begin
        if (iter_sts.done) begin
          len_nxt = iter_q[V-1:0];
          cnt_nxt = '0;
          if (vsel_r) begin
            // zero-length light adds nothing
            state_nxt = (iter_q[V-1:0] == '0) ? S_DONE : S_DOT;
          end else if (mode_r == KIND_BG) begin
            if (iter_q[V-1:0] == '0) begin
              tx_nxt    = Q_W'(HALF_Q15);
              ty_nxt    = Q_W'(HALF_Q15);
              ch_nxt    = '0;
              sub_nxt   = '0;
              state_nxt = S_BLEND;
            end else begin
              tag_nxt   = TAG_X;
              state_nxt = S_KDIV;
            end
          end else if (iter_q[V-1:0] != '0) begin
            state_nxt = S_DOT;
          end else if (has_light_r) begin
            // zero-length ray on a hit: shaded, no outline test
            vsel_nxt  = 1'b1;
            state_nxt = S_SQ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DOT: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (cnt_r == 2'd0);
        mac_a       = MW'(n_r[cnt_r]);
        mac_b       = MW'(vec_c);
        if (cnt_r == 2'd2) begin
          tag_nxt   = vsel_r ? TAG_LIGHT : TAG_OUTL;
          state_nxt = S_KDIV;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end

      S_KDIV: begin
        iter_ctl.start = 1'b1;
        if (tag_r == TAG_X || tag_r == TAG_Y) begin
          neg_nxt  = comp_ext[V];
          iter_src = {SQW'(comp_abs), {Q_FRAC{1'b0}}};
          iter_den = RW'(len_r);
        end else begin
          neg_nxt  = nd[AW];
          iter_src = {nd_abs[SQW-1:0], {Q_FRAC{1'b0}}};
          iter_den = RW'({len_r, {FRAC{1'b0}}});
        end
        state_nxt = S_WDIV;
      end

      S_WDIV: begin
        if (iter_sts.done) begin
          case (tag_r)
            TAG_X: begin
              tx_nxt    = half_c;
              tag_nxt   = TAG_Y;
              state_nxt = S_KDIV;
            end
            TAG_Y: begin
              ty_nxt    = half_c;
              ch_nxt    = '0;
              sub_nxt   = '0;
              state_nxt = S_BLEND;
            end
            TAG_OUTL: begin
              if (c_div < $signed((DW+1)'(OUTLINE_Q15))) begin
                mode_nxt   = KIND_OUTLINE;
                max_nxt[2] = outl_r[23:16];
                max_nxt[1] = outl_r[15:8];
                max_nxt[0] = outl_r[7:0];
                state_nxt  = S_DONE;
              end else if (has_light_r) begin
                vsel_nxt  = 1'b1;
                cnt_nxt   = '0;
                state_nxt = S_SQ;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              c_nxt     = c_div;
              state_nxt = S_BAND;
            end
          endcase
        end
      end

      S_BAND: begin
        if (band_hit) begin
          if (band_rgb[23:16] > max_r[2]) max_nxt[2] = band_rgb[23:16];
          if (band_rgb[15:8]  > max_r[1]) max_nxt[1] = band_rgb[15:8];
          if (band_rgb[7:0]   > max_r[0]) max_nxt[0] = band_rgb[7:0];
        end
        state_nxt = S_DONE;
      end

      S_BLEND: begin
        // per channel: left, right, then the horizontal mix
        sub_nxt    = sub_r + 3'd1;
        mac_ctl.en = 1'b1;
        case (sub_r)
          3'd0: begin
            mac_ctl.clr = 1'b1;
            mac_a = MW'(wy0);
            mac_b = MW'(bgl_r[24 + 8*ch_r +: 8]);
          end
          3'd1: begin
            mac_a = MW'(ty_r);
            mac_b = MW'(bgl_r[8*ch_r +: 8]);
          end
          3'd2: begin
            left_nxt    = acc[MW-1:0];
            mac_ctl.clr = 1'b1;
            mac_a = MW'(wy0);
            mac_b = MW'(bgr_r[24 + 8*ch_r +: 8]);
          end
          3'd3: begin
            mac_a = MW'(ty_r);
            mac_b = MW'(bgr_r[8*ch_r +: 8]);
          end
          3'd4: begin
            mac_ctl.clr = 1'b1;
            mac_a = MW'(wx0);
            mac_b = acc[MW-1:0];
          end
          3'd5: begin
            mac_a = MW'(tx_r);
            mac_b = left_r;
          end
          default: begin
            mac_ctl.en     = 1'b0;
            max_nxt[ch_r]  = rnd_c[BLEND_SHIFT +: 8];
            sub_nxt        = '0;
            ch_nxt         = ch_r + 2'd1;
            if (ch_r == 2'd2) begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end

      S_DONE: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          red_nxt       = widen(max_r[2]);
          green_nxt     = widen(max_r[1]);
          blue_nxt      = widen(max_r[0]);
          kind_nxt      = mode_r;
          out_valid_nxt = 1'b1;
          mid_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      vsel_r      <= 1'b0;
      tag_r       <= TAG_X;
      ch_r        <= '0;
      sub_r       <= '0;
      mode_r      <= KIND_BG;
      mid_r       <= 1'b0;
      max_r[0]    <= '0;
      max_r[1]    <= '0;
      max_r[2]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      vsel_r      <= vsel_nxt;
      tag_r       <= tag_nxt;
      ch_r        <= ch_nxt;
      sub_r       <= sub_nxt;
      mode_r      <= mode_nxt;
      mid_r       <= mid_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r       <= hit_nxt;
    has_light_r <= has_light_nxt;
    last_r      <= last_nxt;
    n_r         <= n_nxt;
    ray_r       <= ray_nxt;
    light_r     <= light_nxt;
    len_r       <= len_nxt;
    neg_r       <= neg_nxt;
    c_r         <= c_nxt;
    tx_r        <= tx_nxt;
    ty_r        <= ty_nxt;
    left_r      <= left_nxt;
    red_r       <= red_nxt;
    green_r     <= green_nxt;
    blue_r      <= blue_nxt;
    kind_r      <= kind_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_pixel_kind = kind_r;

  // ---- checks ----
  `TSP_ASSERT_IMP(a_blend_bg, state_r == S_BLEND, mode_r == KIND_BG, "blend on a hit pixel")
  `TSP_ASSERT_IMP(a_band_light, state_r == S_BAND, mode_r == KIND_BAND && vsel_r, "band pick without light")
  `TSP_ASSERT_IMP(a_iter_wait, iter_sts.done, state_r == S_WSQRT || state_r == S_WDIV, "unit done while not waiting")
  `TSP_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "word taken while busy")

endmodule
`default_nettype wire
